// ===== rtl/core/gmds_pkg.sv =====
`default_nettype none

package gmds_pkg;

   // command codes on req_cmd
   localparam logic [1:0] CMD_WALL  = 2'd0;
   localparam logic [1:0] CMD_SOLVE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // neighbor order of the search
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_VIS_CLR,
      ST_SEED,
      ST_PROBE,
      ST_CHECK,
      ST_POP,
      ST_POP_WAIT,
      ST_PATH_RD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic wall_we;
      logic wall_wd;
      logic vis_we;
      logic vis_wd;
      logic stk_we;
      logic busy;
      logic rsp_valid;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/grid_maze_dfs_solver_core.sv =====
`default_nettype none

// Depth-first maze solver over a GRID_WIDTH x GRID_HEIGHT grid of wall bits.
// A command transfers when start is high and busy is low; busy stays high
// until the single result has been shown for one cycle with rsp_valid.
//   wall write (cmd 0) : result in the cycle after the transfer
//   path read  (cmd 2) : stack RAM read in PATH_RD, then result in RESP
//   solve      (cmd 1) : clear the visited RAM (then straight to RESP if the
//                        start is off the grid), then PROBE per neighbor,
//                        plus CHECK per in-grid probe (wall/visited RAM read
//                        and check), POP and POP_WAIT per pop (stack RAM read), plus SEED and RESP.
//                        The probe/check loop over the wall and visited RAMs
//                        dominates the solve time, since each pop restarts
//                        the probe order at the new top.
// Commands are handled one at a time; the next is taken the cycle after
// rsp_valid. After reset the block sweeps the wall and visited RAMs, one
// entry a cycle over all 2^(XW+YW) entries, with busy high. The receiver cannot
// stall: each result is present for exactly one cycle.
// Path points are stored as {y, x}; point_x/point_y carry the low 5 bits.
module grid_maze_dfs_solver_core #(
   parameter int GRID_WIDTH  = 32,
   parameter int GRID_HEIGHT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [4:0]  req_cell_x,
   input  wire logic [4:0]  req_cell_y,
   input  wire logic        req_wall,
   input  wire logic [4:0]  req_start_x,
   input  wire logic [4:0]  req_start_y,
   input  wire logic [4:0]  req_end_x,
   input  wire logic [4:0]  req_end_y,
   input  wire logic [9:0]  req_path_index,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [10:0]      rsp_path_length,
   output logic [4:0]       rsp_point_x,
   output logic [4:0]       rsp_point_y
);

   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int CAW   = XW + YW;
   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int SAW   = $clog2(CELLS);
   localparam int DW    = $clog2(CELLS + 1);
   localparam int IW    = (DW > 10) ? DW : 10;

   gmds_pkg::state_type state_ff, state_in;
   gmds_pkg::ctl_type   ctl;

   logic [CAW-1:0] sweep_ff, sweep_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic           found_ff, found_in;

   logic [XW-1:0]  tx_ff, tx_in, nx_ff, nx_in, sx_ff, sx_in, ex_ff, ex_in;
   logic [YW-1:0]  ty_ff, ty_in, ny_ff, ny_in, sy_ff, sy_in, ey_ff, ey_in;
   logic [1:0]     dir_ff, dir_in;
   logic           start_ok_ff, start_ok_in;
   logic           target_ok_ff, target_ok_in;
   logic           hit_ff, hit_in;
   logic [4:0]     pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;

   logic           accept;
   logic           sweep_end;
   logic           probe_in_grid;
   logic [XW-1:0]  probe_x;
   logic [YW-1:0]  probe_y;
   logic           cell_open;
   logic           is_target;
   logic           can_push;
   logic           idx_hit;

   logic [CAW-1:0] wall_waddr, vis_waddr, cell_raddr;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [CAW-1:0] stk_wd;
   logic           wall_q, vis_q;
   logic [CAW-1:0] stk_q;

   logic           wall_mem [0:(1 << CAW) - 1];
   logic           vis_mem  [0:(1 << CAW) - 1];
   logic [CAW-1:0] stk_mem  [0:CELLS - 1];

   assign accept    = start && (state_ff == gmds_pkg::ST_IDLE);
   assign sweep_end = (sweep_ff == {CAW{1'b1}});
   assign cell_open = !wall_q && !vis_q;
   assign is_target = target_ok_ff && (nx_ff == ex_ff) && (ny_ff == ey_ff);
   assign can_push  = (int'(depth_ff) < CELLS);
   assign idx_hit   = (IW'(req_path_index) < IW'(depth_ff));

   // neighbor of the stack top in the current direction
   always_comb begin
      probe_x       = tx_ff;
      probe_y       = ty_ff;
      probe_in_grid = 1'b0;
      case (dir_ff)
         gmds_pkg::DIR_RIGHT: begin
            probe_x       = tx_ff + XW'(1);
            probe_in_grid = (int'(tx_ff) + 1 < GRID_WIDTH);
         end
         gmds_pkg::DIR_DOWN: begin
            probe_y       = ty_ff + YW'(1);
            probe_in_grid = (int'(ty_ff) + 1 < GRID_HEIGHT);
         end
         gmds_pkg::DIR_LEFT: begin
            probe_x       = tx_ff - XW'(1);
            probe_in_grid = (tx_ff != '0);
         end
         gmds_pkg::DIR_UP: begin
            probe_y       = ty_ff - YW'(1);
            probe_in_grid = (ty_ff != '0);
         end
         default: begin
            probe_in_grid = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmds_pkg::ST_INIT_CLR: if (sweep_end) state_in = gmds_pkg::ST_IDLE;
         gmds_pkg::ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  gmds_pkg::CMD_SOLVE: state_in = gmds_pkg::ST_VIS_CLR;
                  gmds_pkg::CMD_READ:  state_in = gmds_pkg::ST_PATH_RD;
                  default:             state_in = gmds_pkg::ST_RESP;
               endcase
            end
         end
         gmds_pkg::ST_VIS_CLR: begin
            if (sweep_end) state_in = start_ok_ff ? gmds_pkg::ST_SEED : gmds_pkg::ST_RESP;
         end
         gmds_pkg::ST_SEED: state_in = gmds_pkg::ST_PROBE;
         gmds_pkg::ST_PROBE: begin
            if (probe_in_grid) state_in = gmds_pkg::ST_CHECK;
            else if (dir_ff == gmds_pkg::DIR_UP) state_in = gmds_pkg::ST_POP;
         end
         gmds_pkg::ST_CHECK: begin
            if (cell_open) state_in = is_target ? gmds_pkg::ST_RESP : gmds_pkg::ST_PROBE;
            else if (dir_ff == gmds_pkg::DIR_UP) state_in = gmds_pkg::ST_POP;
            else state_in = gmds_pkg::ST_PROBE;
         end
         gmds_pkg::ST_POP: begin
            state_in = (depth_ff == DW'(1)) ? gmds_pkg::ST_RESP : gmds_pkg::ST_POP_WAIT;
         end
         gmds_pkg::ST_POP_WAIT: state_in = gmds_pkg::ST_PROBE;
         gmds_pkg::ST_PATH_RD:  state_in = gmds_pkg::ST_RESP;
         gmds_pkg::ST_RESP:     state_in = gmds_pkg::ST_IDLE;
         default:               state_in = gmds_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctl = '0;
      ctl.busy = (state_ff != gmds_pkg::ST_IDLE);
      case (state_ff)
         gmds_pkg::ST_INIT_CLR: begin
            ctl.wall_we = 1'b1;
            ctl.vis_we  = 1'b1;
         end
         gmds_pkg::ST_IDLE: begin
            ctl.wall_we = accept && (req_cmd == gmds_pkg::CMD_WALL)
                          && (int'(req_cell_x) < GRID_WIDTH)
                          && (int'(req_cell_y) < GRID_HEIGHT);
            ctl.wall_wd = req_wall;
         end
         gmds_pkg::ST_VIS_CLR: ctl.vis_we = 1'b1;
         gmds_pkg::ST_SEED: begin
            ctl.vis_we = 1'b1;
            ctl.vis_wd = 1'b1;
            ctl.stk_we = 1'b1;
         end
         gmds_pkg::ST_CHECK: begin
            ctl.vis_we = cell_open;
            ctl.vis_wd = 1'b1;
            ctl.stk_we = cell_open && can_push;
         end
         gmds_pkg::ST_RESP: ctl.rsp_valid = 1'b1;
         default: ctl.rsp_valid = 1'b0;
      endcase
   end

   // memory addresses
   always_comb begin
      wall_waddr = sweep_ff;
      vis_waddr  = sweep_ff;
      stk_waddr  = '0;
      stk_wd     = {sy_ff, sx_ff};
      stk_raddr  = SAW'(depth_ff - DW'(2));
      cell_raddr = {probe_y, probe_x};
      if (state_ff == gmds_pkg::ST_IDLE) begin
         wall_waddr = {YW'(req_cell_y), XW'(req_cell_x)};
         stk_raddr  = SAW'(req_path_index);
      end
      if (state_ff == gmds_pkg::ST_SEED) vis_waddr = {sy_ff, sx_ff};
      if (state_ff == gmds_pkg::ST_CHECK) begin
         vis_waddr = {ny_ff, nx_ff};
         stk_waddr = SAW'(depth_ff);
         stk_wd    = {ny_ff, nx_ff};
      end
   end

   // datapath next values
   always_comb begin
      sweep_in     = sweep_ff;
      depth_in     = depth_ff;
      found_in     = found_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      dir_in       = dir_ff;
      start_ok_in  = start_ok_ff;
      target_ok_in = target_ok_ff;
      hit_in       = hit_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      case (state_ff)
         gmds_pkg::ST_INIT_CLR: sweep_in = sweep_ff + CAW'(1);
         gmds_pkg::ST_IDLE: begin
            if (accept) begin
               pt_x_in  = '0;
               pt_y_in  = '0;
               sweep_in = '0;
               hit_in   = idx_hit;
               if (req_cmd == gmds_pkg::CMD_SOLVE) begin
                  depth_in     = '0;
                  found_in     = 1'b0;
                  sx_in        = XW'(req_start_x);
                  sy_in        = YW'(req_start_y);
                  ex_in        = XW'(req_end_x);
                  ey_in        = YW'(req_end_y);
                  start_ok_in  = (int'(req_start_x) < GRID_WIDTH)
                                 && (int'(req_start_y) < GRID_HEIGHT);
                  target_ok_in = (int'(req_end_x) < GRID_WIDTH)
                                 && (int'(req_end_y) < GRID_HEIGHT);
               end
            end
         end
         gmds_pkg::ST_VIS_CLR: sweep_in = sweep_ff + CAW'(1);
         gmds_pkg::ST_SEED: begin
            depth_in = DW'(1);
            tx_in    = sx_ff;
            ty_in    = sy_ff;
            dir_in   = gmds_pkg::DIR_RIGHT;
         end
         gmds_pkg::ST_PROBE: begin
            nx_in = probe_x;
            ny_in = probe_y;
            if (!probe_in_grid) dir_in = dir_ff + 2'd1;
         end
         gmds_pkg::ST_CHECK: begin
            if (cell_open) begin
               dir_in = gmds_pkg::DIR_RIGHT;
               if (can_push) begin
                  depth_in = depth_ff + DW'(1);
                  tx_in    = nx_ff;
                  ty_in    = ny_ff;
               end
               if (is_target) found_in = 1'b1;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         gmds_pkg::ST_POP: depth_in = depth_ff - DW'(1);
         gmds_pkg::ST_POP_WAIT: begin
            tx_in  = stk_q[XW-1:0];
            ty_in  = stk_q[CAW-1:XW];
            dir_in = gmds_pkg::DIR_RIGHT;
         end
         gmds_pkg::ST_PATH_RD: begin
            if (hit_ff) begin
               pt_x_in = 5'(stk_q[XW-1:0]);
               pt_y_in = 5'(stk_q[CAW-1:XW]);
            end
         end
         default: dir_in = dir_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmds_pkg::ST_INIT_CLR;
         sweep_ff <= '0;
         depth_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         depth_ff <= depth_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      dir_ff       <= dir_in;
      start_ok_ff  <= start_ok_in;
      target_ok_ff <= target_ok_in;
      hit_ff       <= hit_in;
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.wall_we) wall_mem[wall_waddr] <= ctl.wall_wd;
      wall_q <= wall_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.vis_we) vis_mem[vis_waddr] <= ctl.vis_wd;
      vis_q <= vis_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.stk_we) stk_mem[stk_waddr] <= stk_wd;
      stk_q <= stk_mem[stk_raddr];
   end

   assign busy            = ctl.busy;
   assign rsp_valid       = ctl.rsp_valid;
   assign rsp_found       = found_ff;
   assign rsp_path_length = 11'(depth_ff);
   assign rsp_point_x     = pt_x_ff;
   assign rsp_point_y     = pt_y_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= CELLS)
      else $error("path stack overflow");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (depth_ff != '0))
      else $error("found reported with empty path");

endmodule

`default_nettype wire
